@@ rtl/uvs_pkg.sv @@
// Shared types, register indexes and the sine table generator for the UV sphere triangle block.
package uvs_pkg;

   // Register indexes on the configuration port (byte address is four times the index).
   localparam logic [1:0] REG_LATITUDE_LINES  = 2'd0;
   localparam logic [1:0] REG_LONGITUDE_LINES = 2'd1;
   localparam logic [1:0] REG_SPHERE_RADIUS   = 2'd2;

   localparam logic [7:0]  LATITUDE_RESET  = 8'd8;
   localparam logic [7:0]  LONGITUDE_RESET = 8'd16;
   localparam logic [14:0] RADIUS_RESET    = 15'd1;

   // Decoded index: which part of the mesh it falls in.
   typedef struct packed {
      logic       oor;
      logic       north;
      logic       south;
      logic       odd;
      logic [7:0] col;
   } dec_type;

   // Per transaction control that follows the angle and product stages.
   typedef struct packed {
      logic       oor;
      logic       pole_n;
      logic       pole_s;
      logic [1:0] lat_neg;
      logic [2:0] ring_sel;
      logic [2:0] col_sel;
   } ctrl_type;

   // Long division by compare and subtract, used only while the table is built.
   function automatic longint unsigned div_small(input longint unsigned num,
                                                 input longint unsigned den);
      longint unsigned rem;
      longint unsigned quo;
      rem = num;
      quo = 64'd0;
      for (int b = 40; b >= 0; b--) begin
         if ((rem >> b) >= den) begin
            rem = rem - (den << b);
            quo = quo | (64'd1 << b);
         end
      end
      return quo;
   endfunction

   // Quarter wave sine entry in Q16, from a Q30 Taylor series to the fifteenth power.
   function automatic logic [16:0] sine_entry(input int unsigned i, input int unsigned bits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      if (i == 0) begin
         return 17'd0;
      end
      if (i >= (32'd1 << bits)) begin
         return 17'd65536;
      end
      x    = ((longint'(i) << (30 - bits)) * 64'd1686629713) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
         term = div_small((term * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
         if ((n & 1) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      sum = (sum + 8192) >>> 14;
      if (sum > 65536) begin
         return 17'd65536;
      end
      return 17'(sum);
   endfunction

endpackage

@@ rtl/uvs_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, several lanes with their own divisors in one pass.
module uvs_div_pipe #(
   parameter int LANES = 1,
   parameter int NW    = 16,
   parameter int DW    = 8,
   parameter int QW    = 8,
   parameter int SW    = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  logic                       in_valid,
   input  logic [LANES-1:0][NW-1:0]   dividend,
   input  logic [LANES-1:0][DW-1:0]   divisor,
   input  logic [SW-1:0]              side_in,
   output logic                       out_valid,
   output logic [LANES-1:0][QW-1:0]   quotient,
   output logic [LANES-1:0][DW-1:0]   remainder,
   output logic [SW-1:0]              side_out
);

   localparam int WW = NW + DW + QW;

   logic                      vld_ff  [QW];
   logic [LANES-1:0][NW-1:0]  rem_ff  [QW];
   logic [LANES-1:0][QW-1:0]  quo_ff  [QW];
   logic [LANES-1:0][DW-1:0]  dvs_ff  [QW];
   logic [SW-1:0]             side_ff [QW];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic                      vld_cur;
      logic [LANES-1:0][NW-1:0]  rem_cur;
      logic [LANES-1:0][QW-1:0]  quo_cur;
      logic [LANES-1:0][DW-1:0]  dvs_cur;
      logic [SW-1:0]             side_cur;
      logic [LANES-1:0][NW-1:0]  rem_in;
      logic [LANES-1:0][QW-1:0]  quo_in;

      if (s == 0) begin : g_first
         assign vld_cur  = in_valid;
         assign rem_cur  = dividend;
         assign quo_cur  = '0;
         assign dvs_cur  = divisor;
         assign side_cur = side_in;
      end else begin : g_rest
         assign vld_cur  = vld_ff[s-1];
         assign rem_cur  = rem_ff[s-1];
         assign quo_cur  = quo_ff[s-1];
         assign dvs_cur  = dvs_ff[s-1];
         assign side_cur = side_ff[s-1];
      end

      // Stage s decides quotient bit QW-1-s.
      always_comb begin
         logic [WW-1:0] shifted;
         logic          ge;
         for (int l = 0; l < LANES; l++) begin
            shifted   = WW'(dvs_cur[l]) << (QW - 1 - s);
            ge        = WW'(rem_cur[l]) >= shifted;
            rem_in[l] = ge ? NW'(WW'(rem_cur[l]) - shifted) : rem_cur[l];
            quo_in[l] = QW'({quo_cur[l], ge});
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (enable) begin
            vld_ff[s] <= vld_cur;
         end
         if (enable) begin
            rem_ff[s]  <= rem_in;
            quo_ff[s]  <= quo_in;
            dvs_ff[s]  <= dvs_cur;
            side_ff[s] <= side_cur;
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign quotient  = quo_ff[QW-1];
   assign side_out  = side_ff[QW-1];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         remainder[l] = rem_ff[QW-1][l][DW-1:0];
      end
   end

endmodule

@@ rtl/uv_sphere_triangle_generator_top.sv @@
// Top level of the UV sphere triangle generator: configuration registers and the corner pipeline.
//
// Each request transaction carries a triangle index; the response transaction returns the three
// corners of that triangle of a UV sphere in Q16.16, or zeros with index_out_of_range set when
// the index is not below 2 * latitude_lines * longitude_lines. Triangles are ordered as the north
// cap fan, then two triangles per quad row by row, then the south cap fan. The block takes one
// transaction per clock while the response is not stalled and returns results in order. Most
// of its depth lies in the pipelined dividers: eight stages split the index into ring and
// column, and SINE_TABLE_BITS + 3 stages form the latitude and longitude phases. A stalled
// response freezes the whole pipeline, so nothing is lost or repeated. Registers are written
// through the APB-style port at byte addresses 0, 4 and 8 and must only change while no
// transaction is in flight.
module uv_sphere_triangle_generator_top #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [16:0]        req_triangle_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_corner_a_x,
   output logic signed [31:0] rsp_corner_a_y,
   output logic signed [31:0] rsp_corner_a_z,
   output logic signed [31:0] rsp_corner_b_x,
   output logic signed [31:0] rsp_corner_b_y,
   output logic signed [31:0] rsp_corner_b_z,
   output logic signed [31:0] rsp_corner_c_x,
   output logic signed [31:0] rsp_corner_c_y,
   output logic signed [31:0] rsp_corner_c_z,
   output logic               rsp_index_out_of_range
);

   localparam int B       = SINE_TABLE_BITS;
   localparam int QUARTER = 1 << B;
   localparam int PW      = B + 2;   // phase width, one full turn
   localparam int IW      = B + 1;   // table index width, 0 .. QUARTER
   localparam int NW4     = B + 12;  // phase divider dividend width
   localparam int QW4     = B + 3;   // phase divider quotient width

   typedef logic [16:0] sine_tbl_type [QUARTER+1];

   function automatic sine_tbl_type build_sine();
      sine_tbl_type t;
      for (int i = 0; i <= QUARTER; i++) begin
         t[i] = uvs_pkg::sine_entry(i, B);
      end
      return t;
   endfunction

   localparam sine_tbl_type SINE_TBL = build_sine();

   // Maps a phase to the table index and the sign of its sine.
   function automatic logic [IW:0] sine_addr(input logic [PW-1:0] p);
      logic [IW-1:0] idx;
      if (p[B]) begin
         idx = IW'(QUARTER) - IW'(p[B-1:0]);
      end else begin
         idx = IW'(p[B-1:0]);
      end
      return {p[B+1], idx};
   endfunction

   // ---------------------------------------------------------------- configuration registers
   logic [7:0]  lat_ff;
   logic [7:0]  lon_ff;
   logic [14:0] rad_ff;
   logic        cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_ff <= uvs_pkg::LATITUDE_RESET;
         lon_ff <= uvs_pkg::LONGITUDE_RESET;
         rad_ff <= uvs_pkg::RADIUS_RESET;
      end else if (cfg_wr) begin
         unique case (paddr[3:2])
            uvs_pkg::REG_LATITUDE_LINES:  lat_ff <= pwdata[7:0];
            uvs_pkg::REG_LONGITUDE_LINES: lon_ff <= pwdata[7:0];
            uvs_pkg::REG_SPHERE_RADIUS:   rad_ff <= pwdata[14:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         uvs_pkg::REG_LATITUDE_LINES:  prdata = {24'd0, lat_ff};
         uvs_pkg::REG_LONGITUDE_LINES: prdata = {24'd0, lon_ff};
         uvs_pkg::REG_SPHERE_RADIUS:   prdata = {17'd0, rad_ff};
         default:                      prdata = 32'd0;
      endcase
   end

   // Triangle counts are registered from the mesh registers and follow them in the next cycle.
   logic [16:0] total_ff;
   logic [16:0] mid_ff;

   always_ff @(posedge clock) begin
      total_ff <= {16'(lat_ff) * 16'(lon_ff), 1'b0};
      mid_ff   <= {16'(lat_ff - 8'd1) * 16'(lon_ff), 1'b0};
   end

   // ---------------------------------------------------------------- pipeline control
   // The whole pipeline advances together whenever the response register can take a value.
   logic rsp_valid_ff;
   logic adv;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;

   // Stage A: captured request.
   logic        va_ff;
   logic [16:0] ta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= req_valid;
      end
      if (adv) begin
         ta_ff <= req_triangle_index;
      end
   end

   // Stage B: classify the index as north cap, quad band or south cap.
   uvs_pkg::dec_type dec_in;
   logic [16:0]      u_in;
   logic             vb_ff;
   uvs_pkg::dec_type dec_b_ff;
   logic [15:0]      q_b_ff;

   always_comb begin
      logic in_mid;
      u_in         = ta_ff - {9'd0, lon_ff};
      in_mid       = u_in < mid_ff;
      dec_in.oor   = ta_ff >= total_ff;
      dec_in.north = ta_ff < {9'd0, lon_ff};
      dec_in.south = !dec_in.north && !in_mid;
      dec_in.odd   = u_in[0];
      dec_in.col   = dec_in.north ? ta_ff[7:0] : 8'(u_in - mid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (adv) begin
         vb_ff <= va_ff;
      end
      if (adv) begin
         dec_b_ff <= dec_in;
         q_b_ff   <= u_in[16:1];
      end
   end

   // Quad number divided by the segment count gives the ring and the column.
   logic                                    v1;
   logic [0:0][7:0]                         ring_q;
   logic [0:0][7:0]                         col_r;
   logic [$bits(uvs_pkg::dec_type)-1:0]     side1;
   uvs_pkg::dec_type                        dec1;

   uvs_div_pipe #(
      .LANES (1),
      .NW    (16),
      .DW    (8),
      .QW    (8),
      .SW    ($bits(uvs_pkg::dec_type))
   ) u_idx_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (vb_ff),
      .dividend  (q_b_ff),
      .divisor   (lon_ff),
      .side_in   (dec_b_ff),
      .out_valid (v1),
      .quotient  (ring_q),
      .remainder (col_r),
      .side_out  (side1)
   );

   assign dec1 = uvs_pkg::dec_type'(side1);

   // Stage C: pick the two rings and two columns, choose corners, form the phase dividends.
   uvs_pkg::ctrl_type         ctrl_in;
   logic [3:0][NW4-1:0]       num_in;
   logic                      vc_ff;
   uvs_pkg::ctrl_type         ctrl_c_ff;
   logic [3:0][NW4-1:0]       num_c_ff;
   logic [3:0][9:0]           den_c_ff;

   always_comb begin
      logic [7:0]  ring [2];
      logic [7:0]  col  [2];
      logic [10:0] n;
      logic [10:0] mag;
      logic [8:0]  d;
      d = {1'b0, lat_ff} + 9'd1;
      if (dec1.south) begin
         ring[0] = lat_ff - 8'd1;
      end else if (dec1.north) begin
         ring[0] = 8'd0;
      end else begin
         ring[0] = ring_q[0];
      end
      col[0]  = (dec1.north || dec1.south) ? dec1.col : col_r[0];
      ring[1] = ring[0] + 8'd1;
      col[1]  = col[0] + 8'd1;

      ctrl_in.oor    = dec1.oor;
      ctrl_in.pole_n = dec1.north;
      ctrl_in.pole_s = dec1.south;
      // Select bits are ordered corner a, b, c from the top bit down.
      priority if (dec1.north) begin
         ctrl_in.ring_sel = 3'b000;
         ctrl_in.col_sel  = 3'b010;
      end else if (dec1.south) begin
         ctrl_in.ring_sel = 3'b000;
         ctrl_in.col_sel  = 3'b001;
      end else if (dec1.odd) begin
         ctrl_in.ring_sel = 3'b001;
         ctrl_in.col_sel  = 3'b011;
      end else begin
         ctrl_in.ring_sel = 3'b011;
         ctrl_in.col_sel  = 3'b010;
      end

      for (int k = 0; k < 2; k++) begin
         n   = {3'd0, lat_ff} - {2'd0, ring[k], 1'b0} - 11'd1;
         ctrl_in.lat_neg[k] = n[10];
         mag = n[10] ? 11'(-n) : n;
         num_in[k]     = (NW4'(mag[7:0]) << (B + 1)) + NW4'(d);
         num_in[k + 2] = (NW4'(col[k]) << (B + 3)) + NW4'(lon_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (adv) begin
         vc_ff <= v1;
      end
      if (adv) begin
         ctrl_c_ff   <= ctrl_in;
         num_c_ff    <= num_in;
         den_c_ff[0] <= {lat_ff + 8'd1 == 8'd0, lat_ff + 8'd1, 1'b0};
         den_c_ff[1] <= {lat_ff + 8'd1 == 8'd0, lat_ff + 8'd1, 1'b0};
         den_c_ff[2] <= {1'b0, lon_ff, 1'b0};
         den_c_ff[3] <= {1'b0, lon_ff, 1'b0};
      end
   end

   // Rounded phases: two latitude lanes and two longitude lanes.
   logic                                  v4;
   logic [3:0][QW4-1:0]                   phase_q;
   logic [$bits(uvs_pkg::ctrl_type)-1:0]  side4;
   uvs_pkg::ctrl_type                     ctrl4;

   uvs_div_pipe #(
      .LANES (4),
      .NW    (NW4),
      .DW    (10),
      .QW    (QW4),
      .SW    ($bits(uvs_pkg::ctrl_type))
   ) u_phase_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (vc_ff),
      .dividend  (num_c_ff),
      .divisor   (den_c_ff),
      .side_in   (ctrl_c_ff),
      .out_valid (v4),
      .quotient  (phase_q),
      .remainder (),
      .side_out  (side4)
   );

   assign ctrl4 = uvs_pkg::ctrl_type'(side4);

   // Stage P1: table addresses. Lookup 2k is the sine of phase k, 2k+1 its cosine.
   logic [7:0][IW-1:0] addr_in;
   logic [7:0]         sgn_in;
   logic               vp1_ff;
   uvs_pkg::ctrl_type  ctrl_p1_ff;
   logic [7:0][IW-1:0] addr_p1_ff;
   logic [7:0]         sgn_p1_ff;

   always_comb begin
      logic [PW-1:0] ph;
      logic [IW:0]   sa;
      logic [IW:0]   ca;
      for (int k = 0; k < 4; k++) begin
         if (k < 2 && ctrl4.lat_neg[k]) begin
            ph = PW'(-phase_q[k]);
         end else begin
            ph = phase_q[k][PW-1:0];
         end
         sa = sine_addr(ph);
         ca = sine_addr(ph + PW'(QUARTER));
         addr_in[2*k]     = sa[IW-1:0];
         sgn_in[2*k]      = sa[IW];
         addr_in[2*k + 1] = ca[IW-1:0];
         sgn_in[2*k + 1]  = ca[IW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vp1_ff <= 1'b0;
      end else if (adv) begin
         vp1_ff <= v4;
      end
      if (adv) begin
         ctrl_p1_ff <= ctrl4;
         addr_p1_ff <= addr_in;
         sgn_p1_ff  <= sgn_in;
      end
   end

   // Stage P2: registered quarter wave table reads.
   logic              vp2_ff;
   uvs_pkg::ctrl_type ctrl_p2_ff;
   logic [7:0][16:0]  mag_p2_ff;
   logic [7:0]        sgn_p2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vp2_ff <= 1'b0;
      end else if (adv) begin
         vp2_ff <= vp1_ff;
      end
      if (adv) begin
         ctrl_p2_ff <= ctrl_p1_ff;
         sgn_p2_ff  <= sgn_p1_ff;
         for (int k = 0; k < 8; k++) begin
            mag_p2_ff[k] <= SINE_TBL[addr_p1_ff[k]];
         end
      end
   end

   // Stage M1: apply signs, select per corner and form the Q16 by Q16 products and the latitude sine times radius.
   logic signed [15:0] rad_s;
   logic              vm1_ff;
   uvs_pkg::ctrl_type ctrl_m1_ff;
   logic signed [35:0] cx_m1_ff [3];
   logic signed [35:0] cz_m1_ff [3];
   logic signed [33:0] yy_m1_ff [3];

   assign rad_s = $signed({1'b0, rad_ff});

   always_ff @(posedge clock) begin
      logic signed [17:0] sv [8];
      logic signed [17:0] clat;
      logic signed [17:0] slat;
      logic signed [17:0] clon;
      logic signed [17:0] slon;
      if (reset) begin
         vm1_ff <= 1'b0;
      end else if (adv) begin
         vm1_ff <= vp2_ff;
      end
      for (int k = 0; k < 8; k++) begin
         sv[k] = sgn_p2_ff[k] ? -$signed({1'b0, mag_p2_ff[k]}) : $signed({1'b0, mag_p2_ff[k]});
      end
      if (adv) begin
         ctrl_m1_ff <= ctrl_p2_ff;
         for (int j = 0; j < 3; j++) begin
            clat = ctrl_p2_ff.ring_sel[2-j] ? sv[3] : sv[1];
            slat = ctrl_p2_ff.ring_sel[2-j] ? sv[2] : sv[0];
            clon = ctrl_p2_ff.col_sel[2-j]  ? sv[7] : sv[5];
            slon = ctrl_p2_ff.col_sel[2-j]  ? sv[6] : sv[4];
            cx_m1_ff[j] <= clat * clon;
            cz_m1_ff[j] <= clat * slon;
            yy_m1_ff[j] <= slat * rad_s;
         end
      end
   end

   // Stage M2: scale the horizontal products by the radius.
   logic              vm2_ff;
   uvs_pkg::ctrl_type ctrl_m2_ff;
   logic signed [51:0] xw_m2_ff [3];
   logic signed [51:0] zw_m2_ff [3];
   logic signed [33:0] yy_m2_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vm2_ff <= 1'b0;
      end else if (adv) begin
         vm2_ff <= vm1_ff;
      end
      if (adv) begin
         ctrl_m2_ff <= ctrl_m1_ff;
         for (int j = 0; j < 3; j++) begin
            xw_m2_ff[j] <= cx_m1_ff[j] * rad_s;
            zw_m2_ff[j] <= cz_m1_ff[j] * rad_s;
            yy_m2_ff[j] <= yy_m1_ff[j];
         end
      end
   end

   // Output stage: round x and z half away from zero, insert the poles, zero out bad indexes.
   // Adding 32767 plus one for non-negative values and shifting gives that rounding in one add.
   logic signed [31:0] x_ff [3];
   logic signed [31:0] y_ff [3];
   logic signed [31:0] z_ff [3];
   logic               oor_ff;

   always_ff @(posedge clock) begin
      logic signed [51:0] tx;
      logic signed [51:0] tz;
      logic        [31:0] pole_y;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vm2_ff;
      end
      pole_y = {1'b0, rad_ff, 16'd0};
      if (adv) begin
         oor_ff <= ctrl_m2_ff.oor;
         for (int j = 0; j < 3; j++) begin
            tx = xw_m2_ff[j] + 52'sd32767 + $signed({51'd0, ~xw_m2_ff[j][51]});
            tz = zw_m2_ff[j] + 52'sd32767 + $signed({51'd0, ~zw_m2_ff[j][51]});
            if (ctrl_m2_ff.oor) begin
               x_ff[j] <= 32'sd0;
               y_ff[j] <= 32'sd0;
               z_ff[j] <= 32'sd0;
            end else if (j == 0 && ctrl_m2_ff.pole_n) begin
               x_ff[j] <= 32'sd0;
               y_ff[j] <= $signed(pole_y);
               z_ff[j] <= 32'sd0;
            end else if (j == 0 && ctrl_m2_ff.pole_s) begin
               x_ff[j] <= 32'sd0;
               y_ff[j] <= $signed(32'd0 - pole_y);
               z_ff[j] <= 32'sd0;
            end else begin
               x_ff[j] <= tx[47:16];
               y_ff[j] <= yy_m2_ff[j][31:0];
               z_ff[j] <= tz[47:16];
            end
         end
      end
   end

   assign rsp_corner_a_x         = x_ff[0];
   assign rsp_corner_a_y         = y_ff[0];
   assign rsp_corner_a_z         = z_ff[0];
   assign rsp_corner_b_x         = x_ff[1];
   assign rsp_corner_b_y         = y_ff[1];
   assign rsp_corner_b_z         = z_ff[1];
   assign rsp_corner_c_x         = x_ff[2];
   assign rsp_corner_c_y         = y_ff[2];
   assign rsp_corner_c_z         = z_ff[2];
   assign rsp_index_out_of_range = oor_ff;

endmodule

@@ rtl/uvs_checker.sv @@
// Port level checker for the UV sphere triangle generator, bound to the top level.
module uvs_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_corner_a_x,
   input logic signed [31:0] rsp_corner_a_y,
   input logic signed [31:0] rsp_corner_a_z,
   input logic signed [31:0] rsp_corner_b_x,
   input logic signed [31:0] rsp_corner_b_y,
   input logic signed [31:0] rsp_corner_b_z,
   input logic signed [31:0] rsp_corner_c_x,
   input logic signed [31:0] rsp_corner_c_y,
   input logic signed [31:0] rsp_corner_c_z,
   input logic               rsp_index_out_of_range
);

   // A response transaction waiting on the consumer stays valid and holds corner a y, corner c z and the range flag.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_corner_a_y) && $stable(rsp_corner_c_z)
         && $stable(rsp_index_out_of_range))
      else $error("response changed while stalled");

   // A stalled response freezes the pipeline, so no request is taken.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request accepted while the pipeline is stalled");

   // Out of range results carry only zero corners.
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_out_of_range |-> rsp_corner_a_x == 0 && rsp_corner_a_y == 0
         && rsp_corner_a_z == 0 && rsp_corner_b_x == 0 && rsp_corner_b_y == 0
         && rsp_corner_b_z == 0 && rsp_corner_c_x == 0 && rsp_corner_c_y == 0
         && rsp_corner_c_z == 0)
      else $error("out of range result with nonzero corners");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind uv_sphere_triangle_generator_top uvs_checker u_uvs_checker (.*);

@@ bench/uv_sphere_triangle_generator_top_tb.sv @@
// Self-checking testbench for the UV sphere triangle generator top level.
module uv_sphere_triangle_generator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_BITS  = 10;
   localparam int QUARTER     = 1 << TABLE_BITS;
   localparam int TURN        = 1 << (TABLE_BITS + 2);
   localparam int DRAIN       = TABLE_BITS + 30;
   localparam int STALL_LIMIT = 5000;
   localparam int LONG_HOLD   = 300;
   localparam int NUM_PHASES  = 8;
   localparam int PHASE_ITEMS = 235;

   // The nine corner coordinates in order a.x .. c.z, plus the range flag.
   typedef struct packed {
      logic [8:0][31:0] coord;
      logic             oor;
   } triangle_type;

   // One directed row; rows marked fixed carry an expected out of range result.
   typedef struct {
      int unsigned index;
      bit          fixed;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   logic        req_valid;
   logic        req_ready;
   logic [16:0] req_triangle_index;
   logic        rsp_valid;
   logic        rsp_ready;
   logic signed [31:0] rsp_corner_a_x, rsp_corner_a_y, rsp_corner_a_z;
   logic signed [31:0] rsp_corner_b_x, rsp_corner_b_y, rsp_corner_b_z;
   logic signed [31:0] rsp_corner_c_x, rsp_corner_c_y, rsp_corner_c_z;
   logic        rsp_index_out_of_range;

   // Shadow copies of the mesh registers that the predictor works from.
   int unsigned mesh_rings;
   int unsigned mesh_segments;
   int unsigned mesh_radius;

   longint      quarter_sine[0:QUARTER];
   triangle_type pending_triangles[$];
   int          error_count;
   int          checked_count;
   int          oor_count;
   int          idle_cycles;
   bit          quiet_mode;
   bit          long_hold_request;

   uv_sphere_triangle_generator_top #(.SINE_TABLE_BITS(TABLE_BITS)) uut (
      .clock(clock), .reset(reset),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_triangle_index(req_triangle_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_corner_a_x(rsp_corner_a_x), .rsp_corner_a_y(rsp_corner_a_y),
      .rsp_corner_a_z(rsp_corner_a_z), .rsp_corner_b_x(rsp_corner_b_x),
      .rsp_corner_b_y(rsp_corner_b_y), .rsp_corner_b_z(rsp_corner_b_z),
      .rsp_corner_c_x(rsp_corner_c_x), .rsp_corner_c_y(rsp_corner_c_y),
      .rsp_corner_c_z(rsp_corner_c_z),
      .rsp_index_out_of_range(rsp_index_out_of_range)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Quarter-wave sine in Q16, built with a Q30 Taylor series up to the x^15 term.
   function automatic longint taylor_sine(int unsigned i);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      if (i == 0) return 0;
      if (i >= QUARTER) return 65536;
      x    = ((64'(i) << (30 - TABLE_BITS)) * 64'd1686629713) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
         term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
         sum  = (n % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      sum = (sum + 8192) >>> 14;
      return (sum > 65536) ? 65536 : sum;
   endfunction

   // Full-turn sine of a phase, folded onto the quarter table.
   function automatic longint phase_sine(int unsigned phase);
      int unsigned p;
      int unsigned offset;
      longint      mag;
      p      = phase & (TURN - 1);
      offset = p & (QUARTER - 1);
      mag    = p[TABLE_BITS] ? quarter_sine[QUARTER - offset] : quarter_sine[offset];
      return p[TABLE_BITS + 1] ? -mag : mag;
   endfunction

   function automatic longint round_q16(longint v);
      longint mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + 32768) >>> 16;
      return (v < 0) ? -mag : mag;
   endfunction

   // Position of one ring vertex; slot selects a, b or c within the triangle.
   function automatic void place_ring_vertex(int unsigned ring, int unsigned col, int slot,
                                             ref triangle_type corners);
      longint          offset;
      longint unsigned mag;
      longint unsigned denom;
      int unsigned     lat_phase;
      int unsigned     lon_phase;
      longint          cos_lat, sin_lat, cos_lon, sin_lon;
      offset    = longint'(mesh_rings) - 2 * longint'(ring) - 1;
      mag       = (offset < 0) ? -offset : offset;
      denom     = mesh_rings + 1;
      lat_phase = int'((mag * (64'd2 << TABLE_BITS) + denom) / (2 * denom));
      if (offset < 0) lat_phase = (TURN - lat_phase) & (TURN - 1);
      lon_phase = int'((64'(col) * (64'd8 << TABLE_BITS) + mesh_segments)
                       / (2 * 64'(mesh_segments)));
      cos_lat = phase_sine(lat_phase + QUARTER);
      sin_lat = phase_sine(lat_phase);
      cos_lon = phase_sine(lon_phase + QUARTER);
      sin_lon = phase_sine(lon_phase);
      corners.coord[3 * slot]     = 32'(round_q16(cos_lat * cos_lon * mesh_radius));
      corners.coord[3 * slot + 1] = 32'(sin_lat * mesh_radius);
      corners.coord[3 * slot + 2] = 32'(round_q16(cos_lat * sin_lon * mesh_radius));
   endfunction

   function automatic triangle_type predict_triangle(int unsigned index);
      triangle_type corners;
      int unsigned  count;
      int unsigned  body;
      int unsigned  band;
      int unsigned  quad;
      int unsigned  row;
      int unsigned  col;
      corners = '0;
      count   = 2 * mesh_rings * mesh_segments;
      if (index >= count) begin
         corners.oor = 1'b1;
         return corners;
      end
      if (index < mesh_segments) begin
         // North cap fan: the pole followed by two vertices of the first ring.
         corners.coord[1] = 32'(mesh_radius * 65536);
         place_ring_vertex(0, index + 1, 1, corners);
         place_ring_vertex(0, index, 2, corners);
         return corners;
      end
      body = index - mesh_segments;
      band = 2 * (mesh_rings - 1) * mesh_segments;
      if (body < band) begin
         quad = body >> 1;
         row  = quad / mesh_segments;
         col  = quad % mesh_segments;
         place_ring_vertex(row, col, 0, corners);
         if (body[0] == 1'b0) begin
            place_ring_vertex(row + 1, col + 1, 1, corners);
            place_ring_vertex(row + 1, col, 2, corners);
         end else begin
            place_ring_vertex(row, col + 1, 1, corners);
            place_ring_vertex(row + 1, col + 1, 2, corners);
         end
      end else begin
         // South cap fan around the lower pole.
         corners.coord[1] = 32'(-longint'(mesh_radius) * 65536);
         place_ring_vertex(mesh_rings - 1, body - band, 1, corners);
         place_ring_vertex(mesh_rings - 1, body - band + 1, 2, corners);
      end
      return corners;
   endfunction

   // Waits the sender's gap, then offers one index and holds it until the transaction.
   task automatic send_index(int unsigned index, bit fixed);
      int unsigned  gap;
      triangle_type expected;
      gap = quiet_mode ? 0 : $urandom_range(0, 9);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_triangle_index <= 17'(index);
      do @(posedge clock); while (!req_ready);
      if (fixed) begin
         expected     = '0;
         expected.oor = 1'b1;
      end else begin
         expected = predict_triangle(index);
      end
      pending_triangles.push_back(expected);
   endtask

   task automatic finish_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Register write and read-back over the APB-style port.
   task automatic write_register(logic [1:0] which, int unsigned value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {which, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata != value) begin
         $display("%0t: register %0d read back expected %0d actual %0d",
                  $realtime, which, value, prdata);
         error_count++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (which)
         uvs_pkg::REG_LATITUDE_LINES:  mesh_rings    = value;
         uvs_pkg::REG_LONGITUDE_LINES: mesh_segments = value;
         default:                      mesh_radius   = value;
      endcase
   endtask

   // The block must be empty before the mesh changes shape.
   task automatic wait_until_drained();
      while (pending_triangles.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic configure_mesh(int unsigned rings, int unsigned segments, int unsigned radius);
      wait_until_drained();
      write_register(uvs_pkg::REG_LATITUDE_LINES, rings);
      write_register(uvs_pkg::REG_LONGITUDE_LINES, segments);
      write_register(uvs_pkg::REG_SPHERE_RADIUS, radius);
   endtask

   // Response side: a random hold-off per transaction, then compare against the oldest
   // expectation field by field. A long hold-off is taken once on request so the
   // pipeline backs up into the request channel.
   initial begin : response_checker
      int unsigned  stall;
      triangle_type actual;
      triangle_type expected;
      forever begin
         if (long_hold_request) begin
            stall             = LONG_HOLD;
            long_hold_request = 1'b0;
         end else begin
            stall = quiet_mode ? 0 : $urandom_range(0, 9);
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
            @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         actual.coord = {rsp_corner_c_z, rsp_corner_c_y, rsp_corner_c_x,
                         rsp_corner_b_z, rsp_corner_b_y, rsp_corner_b_x,
                         rsp_corner_a_z, rsp_corner_a_y, rsp_corner_a_x};
         actual.oor   = rsp_index_out_of_range;
         if (pending_triangles.size() == 0) begin
            $display("%0t: response with no expected transaction, expected none actual oor=%0b",
                     $realtime, actual.oor);
            error_count++;
         end else begin
            expected = pending_triangles.pop_front();
            checked_count++;
            if (expected.oor) oor_count++;
            for (int k = 0; k < 9; k++) begin
               if (actual.coord[k] !== expected.coord[k]) begin
                  $display("%0t: corner %s coord %0d expected %0d actual %0d", $realtime,
                           (k < 3) ? "a" : (k < 6) ? "b" : "c", k % 3,
                           $signed(expected.coord[k]), $signed(actual.coord[k]));
                  error_count++;
               end
            end
            if (actual.oor !== expected.oor) begin
               $display("%0t: index_out_of_range expected %0b actual %0b",
                        $realtime, expected.oor, actual.oor);
               error_count++;
            end
         end
      end
   end

   // Watchdog: any accepted transaction or register access restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
         $display("** uv_sphere_triangle_generator_top: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Main stimulus: directed rows at the reset mesh, then random phases over several meshes.
   initial begin : stimulus
      directed_row_type directed_rows[$];
      int unsigned      rings, segments, radius, count, index;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      req_valid          = 1'b0;
      req_triangle_index = '0;
      rsp_ready          = 1'b0;
      reset              = 1'b1;
      error_count        = 0;
      checked_count      = 0;
      oor_count          = 0;
      idle_cycles        = 0;
      quiet_mode         = 1'b0;
      long_hold_request  = 1'b0;
      for (int i = 0; i <= QUARTER; i++) quarter_sine[i] = taylor_sine(i);
      mesh_rings    = uvs_pkg::LATITUDE_RESET;
      mesh_segments = uvs_pkg::LONGITUDE_RESET;
      mesh_radius   = uvs_pkg::RADIUS_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset mesh is 8 rings by 16 segments, 256 triangles: cover both cap fans, the
      // first and last quad, the seam column, and indices beyond the count.
      directed_rows = '{
         '{0, 0}, '{1, 0}, '{15, 0}, '{16, 0}, '{17, 0}, '{30, 0}, '{31, 0},
         '{100, 0}, '{101, 0}, '{239, 0}, '{240, 0}, '{241, 0}, '{255, 0},
         '{256, 1}, '{257, 1}, '{65536, 1}, '{130049, 1}, '{131071, 1}
      };
      foreach (directed_rows[i]) send_index(directed_rows[i].index, directed_rows[i].fixed);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0:       begin rings = 1;   segments = 1;   radius = 0;     end
            1:       begin rings = 255; segments = 255; radius = 32767; end
            2:       begin rings = 0;   segments = 5;   radius = 100;   end
            3:       begin rings = 7;   segments = 0;   radius = 3;     end
            default: begin
               rings    = $urandom_range(1, 24);
               segments = $urandom_range(1, 24);
               radius   = $urandom_range(0, 32767);
            end
         endcase
         finish_sending();
         configure_mesh(rings, segments, radius);
         // One phase runs with no idling on either side.
         quiet_mode = (phase == 4);
         count      = 2 * rings * segments;
         if (count > 0) begin
            send_index(count - 1, 0);
            send_index(count, 0);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 5 && n == 20) long_hold_request = 1'b1;
            if (phase == 6 && n == 100) begin
               // Sender pause until every outstanding triangle has come back.
               finish_sending();
               while (pending_triangles.size() != 0) @(posedge clock);
            end
            if (count > 0 && $urandom_range(0, 99) < 85) index = $urandom_range(0, count - 1);
            else index = $urandom_range(0, 131071);
            send_index(index, 0);
         end
      end
      finish_sending();
      quiet_mode = 1'b0;
      wait_until_drained();

      $display("Checked %0d triangles (%0d out of range) over %0d mesh settings,",
               checked_count, oor_count, NUM_PHASES + 1);
      $display("including zero-size meshes, the largest mesh and full-scale radius.");
      if (error_count == 0 && pending_triangles.size() == 0) begin
         $display("** uv_sphere_triangle_generator_top: PASSED **");
      end else begin
         $display("** uv_sphere_triangle_generator_top: FAILED **");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/uvs_pkg.sv
rtl/uvs_div_pipe.sv
rtl/uv_sphere_triangle_generator_top.sv
rtl/uvs_checker.sv
bench/uv_sphere_triangle_generator_top_tb.sv
